@@ rtl/core/eas_pkg.sv @@
// shared types, constants and helper function of the experience argmax selector
package eas_pkg;

  localparam int ENTRIES_DEF = 32;
  localparam int DATA_W      = 32;
  localparam int STEP_W      = 31;
  localparam int COUNT_W     = 6;
  localparam int POS_W       = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_START     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_STEP      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE = 2'd2;

  localparam logic [DATA_W-1:0] GRID_START_RST = 32'd0;
  localparam logic [STEP_W-1:0] GRID_STEP_RST  = 31'd4096;
  localparam logic [COUNT_W-1:0] ENTRIES_RST   = 6'd32;

  localparam logic [DATA_W-1:0] POS_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] NEG_MIN = 32'h8000_0000;

  // operation applied to the entry passing the head of the ring
  typedef struct packed {
    logic add_en;
    logic cut_en;
  } eas_head_ctl_t;

  function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? (~v + 32'd1) : v;
  endfunction

endpackage

@@ rtl/core/eas_cell.sv @@
// one score entry of the rotating ring, cleared at reset
module eas_cell
  import eas_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              shift_en,
  input  logic [DATA_W-1:0] score_in,
  output logic [DATA_W-1:0] score_out
);

  logic [DATA_W-1:0] score_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      score_r <= '0;
    end else if (shift_en) begin
      score_r <= score_in;
    end
  end

  assign score_out = score_r;

endmodule

@@ rtl/core/eas_head.sv @@
// update logic at the head of the ring: saturating add and magnitude cut
module eas_head
  import eas_pkg::*;
(
  input  eas_head_ctl_t     ctl,
  input  logic [DATA_W-1:0] score_in,
  input  logic [DATA_W-1:0] delta,
  input  logic [DATA_W-1:0] cut_mag,
  output logic [DATA_W-1:0] score_out
);

  logic [DATA_W:0]   sum;
  logic [DATA_W-1:0] sat_sum;
  logic [DATA_W-1:0] mag;
  logic [DATA_W-1:0] diff;
  logic [DATA_W-1:0] cut_val;

  always_comb begin
    sum = {score_in[DATA_W-1], score_in} + {delta[DATA_W-1], delta};
    if (sum[DATA_W] != sum[DATA_W-1]) begin
      sat_sum = sum[DATA_W] ? NEG_MIN : POS_MAX;
    end else begin
      sat_sum = sum[DATA_W-1:0];
    end

    mag  = magnitude(score_in);
    diff = (mag >= cut_mag) ? (mag - cut_mag) : (cut_mag - mag);
    if (score_in[DATA_W-1]) begin
      cut_val = ~diff + 32'd1;
    end else begin
      cut_val = diff[DATA_W-1] ? POS_MAX : diff;
    end

    if (ctl.add_en) begin
      score_out = sat_sum;
    end else if (ctl.cut_en) begin
      score_out = cut_val;
    end else begin
      score_out = score_in;
    end
  end

endmodule

@@ rtl/core/experience_argmax_selector.sv @@
// top level of the experience argmax selector
//
// The input channel takes one signed Q16.16 experience delta per transfer.
// The delta is added, with saturation, to the score of the current best
// candidate; then the argmax over the active entries is found and every
// active score is cut by the smallest tracked magnitude. Each input transfer
// yields exactly one result transfer carrying the best candidate weight
// (grid_start + index * grid_step, saturated) and its index.
// The score table is a ring of ENTRIES cells that rotates past one update
// unit at its head. One item takes two full turns of the ring and then the
// control states ST_MSET, ST_MUL and ST_EMIT; ST_EMIT waits while the output
// register holds a stalled result. The next input transfer is taken only
// once the sequencer is back in ST_IDLE after the result is posted, so one
// item is in work at a time. The configuration port writes grid_start,
// grid_step and entries_in_use by index; the user must make writes only
// while the block is idle, which the block itself does not enforce.
// Reset (synchronous, rst_n low) clears all scores, both tracked indexes and
// the configuration to its defaults. A stalled result is held in the output
// register while the next input transfer is already taken and worked on;
// that item's result waits until the stalled one has been taken.
module experience_argmax_selector
  import eas_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [DATA_W-1:0] in_experience_delta,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [DATA_W-1:0] out_best_weight,
  output logic [POS_W-1:0]      out_best_position,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W  = (ENTRIES > 2) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int CX_W   = CNT_W + IDX_W + COUNT_W;
  localparam int PROD_W = IDX_W + STEP_W;
  localparam int SUM_W  = PROD_W + 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASS1,
    ST_MSET,
    ST_PASS2,
    ST_MUL,
    ST_EMIT
  } state_t;

  state_t state_r;

  logic [DATA_W-1:0]  grid_start_r;
  logic [STEP_W-1:0]  grid_step_r;
  logic [COUNT_W-1:0] entries_in_use_r;

  logic [IDX_W-1:0]  best_r, smallest_r;
  logic [IDX_W-1:0]  best_use_r, small_use_r;
  logic [IDX_W-1:0]  k_r;
  logic [IDX_W-1:0]  arg_r;
  logic [CNT_W-1:0]  n_r;
  logic [DATA_W-1:0] delta_r;
  logic [DATA_W-1:0] max_r;
  logic [DATA_W-1:0] best_val_r, small_val_r;
  logic [DATA_W-1:0] m_r;
  logic [PROD_W-1:0] prod_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_weight_r;
  logic [POS_W-1:0]  out_pos_r;

  logic [DATA_W-1:0] cell_q [ENTRIES];
  logic [DATA_W-1:0] head_out;
  eas_head_ctl_t     head_ctl;
  logic              shift_en;

  logic [CX_W-1:0]  cnt_x, n_calc_x, n_x, k_x, best_x, small_x;
  logic [CNT_W-1:0] n_calc;
  logic             k_active, k_last;
  logic             new_small;
  logic [SUM_W-1:0] wsum;
  logic [DATA_W-1:0] wsat;
  logic [IDX_W+POS_W-1:0] pos_ext;
  logic             out_free;

  // ring of score cells
  assign shift_en = (state_r == ST_PASS1) || (state_r == ST_PASS2);

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic [DATA_W-1:0] cell_in;
    if (i == ENTRIES - 1) begin : g_tail
      assign cell_in = head_out;
    end else begin : g_mid
      assign cell_in = cell_q[i+1];
    end
    eas_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .score_in (cell_in),
      .score_out(cell_q[i])
    );
  end

  eas_head u_head (
    .ctl      (head_ctl),
    .score_in (cell_q[0]),
    .delta    (delta_r),
    .cut_mag  (m_r),
    .score_out(head_out)
  );

  always_comb begin
    cnt_x    = {{(CNT_W + IDX_W){1'b0}}, entries_in_use_r};
    if (cnt_x == '0) begin
      n_calc_x = CX_W'(1);
    end else if (cnt_x > CX_W'(ENTRIES)) begin
      n_calc_x = CX_W'(ENTRIES);
    end else begin
      n_calc_x = cnt_x;
    end
    n_calc   = n_calc_x[CNT_W-1:0];
    n_x      = {{(IDX_W + COUNT_W){1'b0}}, n_calc};
    best_x   = {{(CNT_W + COUNT_W){1'b0}}, best_r};
    small_x  = {{(CNT_W + COUNT_W){1'b0}}, smallest_r};
    k_x      = {{(CNT_W + COUNT_W){1'b0}}, k_r};
    k_active = k_x < {{(IDX_W + COUNT_W){1'b0}}, n_r};
    k_last   = k_r == IDX_W'(ENTRIES - 1);

    head_ctl.add_en = (state_r == ST_PASS1) && (k_r == best_use_r);
    head_ctl.cut_en = (state_r == ST_PASS2) && k_active;

    new_small = magnitude(best_val_r) < magnitude(small_val_r);

    wsum = {{(SUM_W - DATA_W){grid_start_r[DATA_W-1]}}, grid_start_r} + {2'b00, prod_r};
    if (wsum[SUM_W-1:DATA_W-1] == '0 || wsum[SUM_W-1:DATA_W-1] == '1) begin
      wsat = wsum[DATA_W-1:0];
    end else begin
      wsat = wsum[SUM_W-1] ? NEG_MIN : POS_MAX;
    end
    pos_ext  = {{POS_W{1'b0}}, best_r};
    out_free = !out_valid_r || !out_stall;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_start_r     <= GRID_START_RST;
      grid_step_r      <= GRID_STEP_RST;
      entries_in_use_r <= ENTRIES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRID_START:     grid_start_r     <= cfg_wdata[DATA_W-1:0];
        CFG_GRID_STEP:      grid_step_r      <= cfg_wdata[STEP_W-1:0];
        CFG_ENTRIES_IN_USE: entries_in_use_r <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      best_r      <= '0;
      smallest_r  <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != ST_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            delta_r     <= in_experience_delta;
            n_r         <= n_calc;
            best_use_r  <= (best_x >= n_x) ? '0 : best_r;
            small_use_r <= (small_x >= n_x) ? '0 : smallest_r;
            k_r         <= '0;
            state_r     <= ST_PASS1;
          end
        end
        ST_PASS1: begin
          if (k_r == '0) begin
            max_r <= head_out;
            arg_r <= '0;
          end else if (k_active && ($signed(head_out) > $signed(max_r))) begin
            max_r <= head_out;
            arg_r <= k_r;
          end
          if (k_r == best_use_r) begin
            best_val_r <= head_out;
          end
          if (k_r == small_use_r) begin
            small_val_r <= head_out;
          end
          if (k_last) begin
            k_r     <= '0;
            state_r <= ST_MSET;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        ST_MSET: begin
          m_r        <= new_small ? magnitude(best_val_r) : magnitude(small_val_r);
          smallest_r <= new_small ? best_use_r : small_use_r;
          best_r     <= arg_r;
          state_r    <= ST_PASS2;
        end
        ST_PASS2: begin
          if (k_last) begin
            k_r     <= '0;
            state_r <= ST_MUL;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        ST_MUL: begin
          prod_r  <= PROD_W'(best_r) * PROD_W'(grid_step_r);
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_weight_r <= wsat;
            out_pos_r    <= pos_ext[POS_W-1:0];
            out_valid_r  <= 1'b1;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall          = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_best_weight   = out_weight_r;
  assign out_best_position = out_pos_r;

endmodule
